// ----- hw/rtl/clfp_pkg.sv -----
// Shared constants, types and helper functions of the contact list field parser.
`default_nettype none

package clfp_pkg;

    localparam int MASK_MAX   = 32;
    localparam int MASK_IDX_W = (MASK_MAX > 1) ? $clog2(MASK_MAX) : 1;
    localparam int MASK_LEN_W = $clog2(MASK_MAX + 1);

    localparam int WORD_BYTES = 4;
    localparam int WORD_W     = 8 * WORD_BYTES;
    localparam int ACC_W      = 8 * (WORD_BYTES - 1);
    localparam int BIW_W      = $clog2(WORD_BYTES);

    localparam int COUNT_W = 16;
    localparam int KIND_W  = 3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    localparam logic [7:0] CHAR_U = 8'h75;
    localparam logic [7:0] CHAR_S = 8'h73;

    localparam logic [0:0] REG_OK_STATUS = 1'b0;

    localparam logic [KIND_W-1:0] KIND_NAME          = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DONE          = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_STATUS    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TRUNCATED     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MASK_OVERFLOW = 3'd4;

    typedef logic [MASK_IDX_W-1:0] mask_idx_t;
    typedef logic [MASK_LEN_W-1:0] mask_len_t;
    typedef logic [MASK_MAX-1:0]   mask_vec_t;
    typedef logic [WORD_W-1:0]     word_t;
    typedef logic [ACC_W-1:0]      acc_t;
    typedef logic [BIW_W-1:0]      biw_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [RQ_PTR_W-1:0]   rq_ptr_t;
    typedef logic [RQ_CNT_W-1:0]   rq_count_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [7:0]        name_byte;
        logic              end_of_name;
        count_t            contact_number;
        count_t            names_found;
        logic              last_of_run;
    } result_t;

    typedef struct packed {
        logic    a_valid;
        result_t a;
        logic    b_valid;
        result_t b;
    } result_pair_t;

    typedef struct packed {
        rq_count_t count;
        logic      room;
    } queue_status_t;

    typedef struct packed {
        logic      en;
        mask_idx_t index;
        logic [7:0] code;
    } mask_write_t;

    typedef struct packed {
        mask_vec_t takes;
        mask_vec_t is_s;
    } mask_view_t;

    typedef struct packed {
        logic      found;
        mask_idx_t index;
    } field_hit_t;

    function automatic logic takes_bytes(logic [7:0] code);
        return (code == CHAR_U) || (code == CHAR_S);
    endfunction

    // Lowest byte-taking field at or above the start index and below the mask length.
    function automatic field_hit_t find_field(mask_vec_t takes, mask_len_t len,
                                              mask_len_t start);
        field_hit_t hit;
        hit.found = 1'b0;
        hit.index = '0;
        for (int i = MASK_MAX - 1; i >= 0; i--)
        begin
            if (takes[i] && (mask_len_t'(i) >= start) && (mask_len_t'(i) < len))
            begin
                hit.found = 1'b1;
                hit.index = mask_idx_t'(i);
            end
        end
        return hit;
    endfunction

    function automatic logic any_field(mask_vec_t takes, mask_len_t len);
        field_hit_t hit;
        hit = find_field(takes, len, '0);
        return hit.found;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/clfp_stream_if.sv -----
// Valid/ready stream interfaces for payload bytes and parser results.
`default_nettype none

interface clfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface clfp_result_if;
    logic                         valid;
    logic                         ready;
    logic [clfp_pkg::KIND_W-1:0]  result_kind;
    logic [7:0]                   name_byte;
    logic                         end_of_name;
    logic [clfp_pkg::COUNT_W-1:0] contact_number;
    logic [clfp_pkg::COUNT_W-1:0] names_found;
    logic                         last_of_run;

    modport source (output valid, output result_kind, output name_byte, output end_of_name,
                    output contact_number, output names_found, output last_of_run,
                    input ready);
    modport sink (input valid, input result_kind, input name_byte, input end_of_name,
                  input contact_number, input names_found, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/clfp_apb_regs.sv -----
// APB configuration register holding the expected status word.
`default_nettype none

module clfp_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clfp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [clfp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [clfp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output clfp_pkg::word_t                   ok_status_word
);

    logic [0:0]      reg_index;
    logic            write_en;
    clfp_pkg::word_t ok_status_reg;

    assign reg_index = paddr[clfp_pkg::APB_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign write_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_status_reg <= '0;
        end
        else if (write_en && (reg_index == clfp_pkg::REG_OK_STATUS))
        begin
            ok_status_reg <= pwdata;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            clfp_pkg::REG_OK_STATUS: prdata = ok_status_reg;
            default:                 prdata = '0;
        endcase
    end

    assign ok_status_word = ok_status_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/clfp_mask_store.sv -----
// Field mask store keeping the class of each mask character, with write-through view.
`default_nettype none

module clfp_mask_store (
    input  logic                  clk,
    input  clfp_pkg::mask_write_t wr,
    output clfp_pkg::mask_view_t  view
);

    clfp_pkg::mask_vec_t takes_reg;
    clfp_pkg::mask_vec_t is_s_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            takes_reg[wr.index] <= clfp_pkg::takes_bytes(wr.code);
            is_s_reg[wr.index]  <= (wr.code == clfp_pkg::CHAR_S);
        end
    end

    // The character written in this cycle is already visible to the parse logic.
    always_comb
    begin
        view.takes = takes_reg;
        view.is_s  = is_s_reg;
        if (wr.en)
        begin
            view.takes[wr.index] = clfp_pkg::takes_bytes(wr.code);
            view.is_s[wr.index]  = (wr.code == clfp_pkg::CHAR_S);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/clfp_parser.sv -----
// Input register and combinational parse step over the contact list byte stream.
`default_nettype none

module clfp_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    clfp_byte_if.sink               byte_stream,
    input  clfp_pkg::word_t         ok_status_word,
    input  clfp_pkg::queue_status_t queue_status,
    input  clfp_pkg::mask_view_t    group_view,
    input  clfp_pkg::mask_view_t    contact_view,
    output clfp_pkg::mask_write_t   group_write,
    output clfp_pkg::mask_write_t   contact_write,
    output clfp_pkg::result_pair_t  results
);

    localparam logic [3:0] PH_STATUS   = 4'd0;
    localparam logic [3:0] PH_GCOUNT   = 4'd1;
    localparam logic [3:0] PH_GMLEN    = 4'd2;
    localparam logic [3:0] PH_GMASK    = 4'd3;
    localparam logic [3:0] PH_CMLEN    = 4'd4;
    localparam logic [3:0] PH_CMASK    = 4'd5;
    localparam logic [3:0] PH_GROUPS   = 4'd6;
    localparam logic [3:0] PH_CONTACTS = 4'd7;
    localparam logic [3:0] PH_DEAD     = 4'd8;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       step;

    logic [3:0]          phase_reg, phase_pre, phase_set, phase_next;
    clfp_pkg::biw_t      biw_reg, biw_pre, biw_next;
    clfp_pkg::acc_t      acc_reg, acc_pre, acc_next, acc_take;
    clfp_pkg::word_t     gcount_reg, gcount_pre, gcount_next;
    clfp_pkg::word_t     gidx_reg, gidx_pre, gidx_set, gidx_next, gidx_inc;
    clfp_pkg::mask_len_t glen_reg, glen_pre, glen_next;
    clfp_pkg::mask_len_t clen_reg, clen_pre, clen_next;
    clfp_pkg::mask_len_t fidx_reg, fidx_pre, fidx_set, fidx_next, fidx_inc;
    clfp_pkg::word_t     sbl_reg, sbl_pre, sbl_next;
    logic                taken_reg, taken_pre, taken_set, taken_next;
    logic                live_reg, live_pre, live_next;
    logic                open_reg, open_pre, open_set, open_next;
    clfp_pkg::count_t    contact_reg, contact_pre, contact_set, contact_next;
    clfp_pkg::count_t    names_reg, names_pre, names_next;

    logic                 do_settle;
    logic                 to_contacts;
    logic                 word_done;
    clfp_pkg::word_t      word_value;
    logic                 cur_is_s;
    logic                 contact_any_now;
    clfp_pkg::field_hit_t g_hit, g_first, c_hit, c_first;
    logic                 res_a_valid, res_b_valid;
    clfp_pkg::result_t    res_a, res_b;

    // Input register: a byte moves on when the result queue can take two results.
    assign step              = in_valid_reg && queue_status.room;
    assign byte_stream.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_stream.ready)
        begin
            in_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.ready && byte_stream.valid)
        begin
            in_byte_reg <= byte_stream.payload_byte;
            in_last_reg <= byte_stream.last_byte;
        end
    end

    assign word_done  = (biw_reg == clfp_pkg::biw_t'(clfp_pkg::WORD_BYTES - 1));
    assign word_value = {in_byte_reg, acc_reg};
    assign fidx_inc   = fidx_reg + 1'b1;
    assign cur_is_s   = (phase_reg == PH_GROUPS)
                      ? group_view.is_s[fidx_reg[clfp_pkg::MASK_IDX_W-1:0]]
                      : contact_view.is_s[fidx_reg[clfp_pkg::MASK_IDX_W-1:0]];
    assign contact_any_now = clfp_pkg::any_field(contact_view.takes, clen_reg);

    always_comb
    begin
        acc_take = (biw_reg == '0) ? '0 : acc_reg;
        for (int j = 0; j < clfp_pkg::WORD_BYTES - 1; j++)
        begin
            if (biw_reg == clfp_pkg::biw_t'(j))
            begin
                acc_take[8*j +: 8] = in_byte_reg;
            end
        end
    end

    always_comb
    begin
        group_write.en      = step && (phase_reg == PH_GMASK);
        group_write.index   = fidx_reg[clfp_pkg::MASK_IDX_W-1:0];
        group_write.code    = in_byte_reg;
        contact_write.en    = step && (phase_reg == PH_CMASK);
        contact_write.index = fidx_reg[clfp_pkg::MASK_IDX_W-1:0];
        contact_write.code  = in_byte_reg;
    end

    // Effect of one byte before the walk to the next byte-taking field.
    always_comb
    begin
        phase_pre   = phase_reg;
        biw_pre     = biw_reg;
        acc_pre     = acc_reg;
        gcount_pre  = gcount_reg;
        gidx_pre    = gidx_reg;
        glen_pre    = glen_reg;
        clen_pre    = clen_reg;
        fidx_pre    = fidx_reg;
        sbl_pre     = sbl_reg;
        taken_pre   = taken_reg;
        live_pre    = live_reg;
        open_pre    = open_reg;
        contact_pre = contact_reg;
        names_pre   = names_reg;
        do_settle   = 1'b0;
        res_a_valid = 1'b0;
        res_a       = '0;
        res_a.contact_number = contact_reg;
        res_a.names_found    = names_reg;

        if (step)
        begin
            unique case (phase_reg)
                PH_STATUS:
                begin
                    biw_pre = biw_reg + 1'b1;
                    acc_pre = acc_take;
                    if (word_done)
                    begin
                        if (word_value != ok_status_word)
                        begin
                            res_a_valid       = 1'b1;
                            res_a.result_kind = clfp_pkg::KIND_BAD_STATUS;
                            phase_pre         = PH_DEAD;
                        end
                        else
                        begin
                            phase_pre = PH_GCOUNT;
                        end
                    end
                end
                PH_GCOUNT:
                begin
                    biw_pre = biw_reg + 1'b1;
                    acc_pre = acc_take;
                    if (word_done)
                    begin
                        gcount_pre = word_value;
                        phase_pre  = PH_GMLEN;
                    end
                end
                PH_GMLEN, PH_CMLEN:
                begin
                    biw_pre = biw_reg + 1'b1;
                    acc_pre = acc_take;
                    if (word_done)
                    begin
                        if (word_value > clfp_pkg::word_t'(clfp_pkg::MASK_MAX))
                        begin
                            res_a_valid       = 1'b1;
                            res_a.result_kind = clfp_pkg::KIND_MASK_OVERFLOW;
                            phase_pre         = PH_DEAD;
                        end
                        else if (phase_reg == PH_GMLEN)
                        begin
                            glen_pre  = word_value[clfp_pkg::MASK_LEN_W-1:0];
                            fidx_pre  = '0;
                            phase_pre = (word_value != '0) ? PH_GMASK : PH_CMLEN;
                        end
                        else
                        begin
                            clen_pre = word_value[clfp_pkg::MASK_LEN_W-1:0];
                            fidx_pre = '0;
                            if (word_value != '0)
                            begin
                                phase_pre = PH_CMASK;
                            end
                            else
                            begin
                                phase_pre = PH_GROUPS;
                                gidx_pre  = '0;
                                do_settle = 1'b1;
                            end
                        end
                    end
                end
                PH_GMASK:
                begin
                    if (fidx_inc >= glen_reg)
                    begin
                        fidx_pre  = '0;
                        phase_pre = PH_CMLEN;
                    end
                    else
                    begin
                        fidx_pre = fidx_inc;
                    end
                end
                PH_CMASK:
                begin
                    if (fidx_inc >= clen_reg)
                    begin
                        phase_pre = PH_GROUPS;
                        gidx_pre  = '0;
                        fidx_pre  = '0;
                        do_settle = 1'b1;
                    end
                    else
                    begin
                        fidx_pre = fidx_inc;
                    end
                end
                PH_GROUPS, PH_CONTACTS:
                begin
                    if ((phase_reg == PH_GROUPS) || contact_any_now)
                    begin
                        if (phase_reg == PH_CONTACTS)
                        begin
                            open_pre = 1'b1;
                        end
                        if (sbl_reg != '0)
                        begin
                            sbl_pre = sbl_reg - 1'b1;
                            if (live_reg)
                            begin
                                if ((sbl_reg == 1) && (names_reg != '1))
                                begin
                                    names_pre = names_reg + 1'b1;
                                end
                                res_a_valid       = 1'b1;
                                res_a.result_kind = clfp_pkg::KIND_NAME;
                                res_a.name_byte   = in_byte_reg;
                                res_a.end_of_name = (sbl_reg == 1);
                                res_a.names_found = names_pre;
                            end
                            if (sbl_reg == 1)
                            begin
                                fidx_pre  = fidx_inc;
                                live_pre  = 1'b0;
                                do_settle = 1'b1;
                            end
                        end
                        else
                        begin
                            biw_pre = biw_reg + 1'b1;
                            acc_pre = acc_take;
                            if (word_done)
                            begin
                                if (cur_is_s && (word_value != '0))
                                begin
                                    sbl_pre = word_value;
                                    if ((phase_reg == PH_CONTACTS) && !taken_reg)
                                    begin
                                        taken_pre = 1'b1;
                                        live_pre  = 1'b1;
                                    end
                                end
                                else
                                begin
                                    fidx_pre  = fidx_inc;
                                    live_pre  = 1'b0;
                                    do_settle = 1'b1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign g_hit    = clfp_pkg::find_field(group_view.takes, glen_pre, fidx_pre);
    assign g_first  = clfp_pkg::find_field(group_view.takes, glen_pre, '0);
    assign c_hit    = clfp_pkg::find_field(contact_view.takes, clen_pre, fidx_pre);
    assign c_first  = clfp_pkg::find_field(contact_view.takes, clen_pre, '0);
    assign gidx_inc = gidx_pre + 1'b1;

    // Walk past fields, records and groups that take no bytes.
    always_comb
    begin
        phase_set   = phase_pre;
        gidx_set    = gidx_pre;
        fidx_set    = fidx_pre;
        taken_set   = taken_pre;
        open_set    = open_pre;
        contact_set = contact_pre;
        to_contacts = 1'b0;

        if (do_settle)
        begin
            if (phase_pre == PH_GROUPS)
            begin
                if ((gidx_pre >= gcount_pre) || !g_first.found)
                begin
                    to_contacts = 1'b1;
                end
                else if (g_hit.found)
                begin
                    fidx_set = clfp_pkg::mask_len_t'(g_hit.index);
                end
                else if (gidx_inc >= gcount_pre)
                begin
                    gidx_set    = gidx_inc;
                    to_contacts = 1'b1;
                end
                else
                begin
                    gidx_set = gidx_inc;
                    fidx_set = clfp_pkg::mask_len_t'(g_first.index);
                end
            end
            if ((phase_pre == PH_CONTACTS) || to_contacts)
            begin
                phase_set = PH_CONTACTS;
                if (to_contacts)
                begin
                    fidx_set = '0;
                end
                if (c_first.found)
                begin
                    if (to_contacts)
                    begin
                        fidx_set = clfp_pkg::mask_len_t'(c_first.index);
                    end
                    else if (c_hit.found)
                    begin
                        fidx_set = clfp_pkg::mask_len_t'(c_hit.index);
                    end
                    else
                    begin
                        if (contact_pre != '1)
                        begin
                            contact_set = contact_pre + 1'b1;
                        end
                        taken_set = 1'b0;
                        open_set  = 1'b0;
                        fidx_set  = clfp_pkg::mask_len_t'(c_first.index);
                    end
                end
            end
        end
    end

    // End of payload: report the position unless the payload was already rejected, then return to the start of a list.
    always_comb
    begin
        phase_next   = phase_set;
        biw_next     = biw_pre;
        acc_next     = acc_pre;
        gcount_next  = gcount_pre;
        gidx_next    = gidx_set;
        glen_next    = glen_pre;
        clen_next    = clen_pre;
        fidx_next    = fidx_set;
        sbl_next     = sbl_pre;
        taken_next   = taken_set;
        live_next    = live_pre;
        open_next    = open_set;
        contact_next = contact_set;
        names_next   = names_pre;
        res_b_valid  = 1'b0;
        res_b        = '0;
        res_b.contact_number = contact_set;
        res_b.names_found    = names_pre;
        res_b.last_of_run    = 1'b1;

        if (step && in_last_reg)
        begin
            if (phase_set != PH_DEAD)
            begin
                res_b_valid       = 1'b1;
                res_b.result_kind = ((phase_set == PH_CONTACTS) && !open_set)
                                  ? clfp_pkg::KIND_DONE : clfp_pkg::KIND_TRUNCATED;
            end
            phase_next   = PH_STATUS;
            biw_next     = '0;
            acc_next     = '0;
            gcount_next  = '0;
            gidx_next    = '0;
            glen_next    = '0;
            clen_next    = '0;
            fidx_next    = '0;
            sbl_next     = '0;
            taken_next   = 1'b0;
            live_next    = 1'b0;
            open_next    = 1'b0;
            contact_next = '0;
            names_next   = '0;
        end
    end

    always_comb
    begin
        results.a_valid = res_a_valid || res_b_valid;
        results.a       = res_a_valid ? res_a : res_b;
        results.a.last_of_run = !(res_a_valid && res_b_valid);
        results.b_valid = res_a_valid && res_b_valid;
        results.b       = res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_STATUS;
            biw_reg     <= '0;
            acc_reg     <= '0;
            gcount_reg  <= '0;
            gidx_reg    <= '0;
            glen_reg    <= '0;
            clen_reg    <= '0;
            fidx_reg    <= '0;
            sbl_reg     <= '0;
            taken_reg   <= 1'b0;
            live_reg    <= 1'b0;
            open_reg    <= 1'b0;
            contact_reg <= '0;
            names_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            biw_reg     <= biw_next;
            acc_reg     <= acc_next;
            gcount_reg  <= gcount_next;
            gidx_reg    <= gidx_next;
            glen_reg    <= glen_next;
            clen_reg    <= clen_next;
            fidx_reg    <= fidx_next;
            sbl_reg     <= sbl_next;
            taken_reg   <= taken_next;
            live_reg    <= live_next;
            open_reg    <= open_next;
            contact_reg <= contact_next;
            names_reg   <= names_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/clfp_result_queue.sv -----
// Result queue that takes up to two results per cycle and drives the result stream.
`default_nettype none

module clfp_result_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  clfp_pkg::result_pair_t  results,
    clfp_result_if.source           result_stream,
    output clfp_pkg::queue_status_t queue_status
);

    clfp_pkg::result_t   entry_reg [clfp_pkg::RQ_DEPTH];
    clfp_pkg::rq_ptr_t   head_reg;
    clfp_pkg::rq_count_t count_reg;
    clfp_pkg::rq_ptr_t   tail;
    clfp_pkg::rq_ptr_t   tail_b;
    clfp_pkg::result_t   head_entry;
    logic                pop;

    assign tail   = head_reg + count_reg[clfp_pkg::RQ_PTR_W-1:0];
    assign tail_b = tail + 1'b1;
    assign pop    = result_stream.valid && result_stream.ready;

    always_ff @(posedge clk)
    begin
        if (results.a_valid)
        begin
            entry_reg[tail] <= results.a;
        end
        if (results.b_valid)
        begin
            entry_reg[tail_b] <= results.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_reg + clfp_pkg::rq_ptr_t'(pop);
            count_reg <= count_reg + clfp_pkg::rq_count_t'(results.a_valid)
                       + clfp_pkg::rq_count_t'(results.b_valid)
                       - clfp_pkg::rq_count_t'(pop);
        end
    end

    assign head_entry = entry_reg[head_reg];

    assign result_stream.valid          = (count_reg != '0);
    assign result_stream.result_kind    = head_entry.result_kind;
    assign result_stream.name_byte      = head_entry.name_byte;
    assign result_stream.end_of_name    = head_entry.end_of_name;
    assign result_stream.contact_number = head_entry.contact_number;
    assign result_stream.names_found    = head_entry.names_found;
    assign result_stream.last_of_run    = head_entry.last_of_run;

    assign queue_status.count = count_reg;
    assign queue_status.room  = (count_reg <= clfp_pkg::rq_count_t'(clfp_pkg::RQ_DEPTH - 2));

endmodule

`default_nettype wire

// ----- hw/rtl/contact_list_field_parser_top.sv -----
// Top level of the contact list field parser.
`default_nettype none

// The parser takes one payload byte per cycle and extracts, from every contact record, the
// first non-empty string field as that contact's name, one result per name byte, plus one
// status result for each payload. A transferred byte waits in an input register until the
// queue has room, is then parsed against the stored masks, and its results are registered
// into a four-entry result queue. The input accepts a byte in every cycle as long as the
// queue has two free entries; the result side drains one result per cycle while the result
// stream is ready, and only a final byte that carries a name byte gives two results. The
// expected status word is written through the APB port at byte address 0; the user must
// write it only while no payload is in flight, as the block does not enforce this.
module contact_list_field_parser_top (
    input  logic                            clk,
    input  logic                            rst_n,
    clfp_byte_if.sink                       byte_stream,
    clfp_result_if.source                   result_stream,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [clfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [clfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    clfp_pkg::word_t         ok_status_word;
    clfp_pkg::mask_write_t   group_write;
    clfp_pkg::mask_write_t   contact_write;
    clfp_pkg::mask_view_t    group_view;
    clfp_pkg::mask_view_t    contact_view;
    clfp_pkg::result_pair_t  results;
    clfp_pkg::queue_status_t queue_status;

    clfp_apb_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .ok_status_word (ok_status_word)
    );

    clfp_mask_store u_group_mask (
        .clk  (clk),
        .wr   (group_write),
        .view (group_view)
    );

    clfp_mask_store u_contact_mask (
        .clk  (clk),
        .wr   (contact_write),
        .view (contact_view)
    );

    clfp_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_stream    (byte_stream),
        .ok_status_word (ok_status_word),
        .queue_status   (queue_status),
        .group_view     (group_view),
        .contact_view   (contact_view),
        .group_write    (group_write),
        .contact_write  (contact_write),
        .results        (results)
    );

    clfp_result_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .results       (results),
        .result_stream (result_stream),
        .queue_status  (queue_status)
    );

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_status.count <= clfp_pkg::RQ_DEPTH)
        else $error("Result queue holds more entries than its depth.");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        results.a_valid |-> queue_status.room)
        else $error("Results pushed while the queue lacks room for two entries.");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        results.b_valid |-> (results.a_valid && !results.a.last_of_run
            && ((results.b.result_kind == clfp_pkg::KIND_DONE)
            || (results.b.result_kind == clfp_pkg::KIND_TRUNCATED))))
        else $error("Second result of a byte is not an end-of-payload report.");
`endif

endmodule

`default_nettype wire
